// File: rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the run-length block decoder.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned LENGTH_W = 16;

  // Control byte layout: bit 7 marks a repeated run, the low bits hold a count.
  localparam int unsigned CTRL_RUN_BIT = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  localparam logic [LENGTH_W-1:0] OUTPUT_LENGTH_RESET = 16'd768;
  localparam logic [LENGTH_W-1:0] CONSUMED_MAX        = 16'hFFFF;

  // One decoded run: a byte value, how many copies of it to output, and whether it ends the block.
  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] repeat_res;
    logic               block_last;
  } rbd_result_t;

endpackage

// File: rtl/rbd_front.sv
// ----------------------------------------------------------------------------
// rbd_front
// Stream parser: walks the header, control and data bytes of each block,
// keeps the block counters and hands finished runs to the result queue.
// ----------------------------------------------------------------------------
module rbd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     cfg_valid_i,
  input  logic [15:0]              cfg_output_length_i,
  output logic                     res_valid_o,
  output rbd_pkg::rbd_result_t     res_o
);
  import rbd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR_LO = 3'd0,
    PH_HDR_HI = 3'd1,
    PH_CTRL   = 3'd2,
    PH_RUN    = 3'd3,
    PH_LIT    = 3'd4,
    PH_PASS   = 3'd5,
    PH_SKIP   = 3'd6
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [BYTE_W-1:0]     header_low_r, header_low_nxt;
  logic [LENGTH_W-1:0]   block_size_r, block_size_nxt;
  logic [LENGTH_W-1:0]   consumed_r, consumed_nxt;
  logic [LENGTH_W-1:0]   produced_r, produced_nxt;
  logic [COUNT_W-1:0]    literal_left_r, literal_left_nxt;
  logic [COUNT_W-1:0]    run_count_r, run_count_nxt;
  logic [LENGTH_W-1:0]   output_length_r, output_length_nxt;

  logic                  in_block;
  logic [LENGTH_W-1:0]   consumed_inc;
  logic [LENGTH_W-1:0]   remaining;
  logic [LENGTH_W-1:0]   ctrl_count;
  logic [COUNT_W-1:0]    emit_n;
  logic                  do_emit;
  logic [LENGTH_W-1:0]   produced_sum;
  logic                  emit_last;

  assign in_block = (phase_r == PH_CTRL) || (phase_r == PH_RUN) ||
                    (phase_r == PH_LIT)  || (phase_r == PH_PASS);

  assign remaining = (output_length_r > produced_r) ?
                     (output_length_r - produced_r) : '0;
  assign ctrl_count = {{(LENGTH_W-COUNT_W){1'b0}}, data_byte_i[COUNT_W-1:0]};

  always_comb begin
    consumed_inc = consumed_r;
    if ((in_block || phase_r == PH_SKIP) && consumed_r != CONSUMED_MAX) begin
      consumed_inc = consumed_r + 16'd1;
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    header_low_nxt    = header_low_r;
    block_size_nxt    = block_size_r;
    consumed_nxt      = consumed_r;
    produced_nxt      = produced_r;
    literal_left_nxt  = literal_left_r;
    run_count_nxt     = run_count_r;
    output_length_nxt = output_length_r;
    do_emit           = 1'b0;
    emit_n            = '0;

    if (accept_i) begin
      consumed_nxt = consumed_inc;
      case (phase_r)
        PH_HDR_HI: begin
          block_size_nxt   = {data_byte_i, header_low_r};
          consumed_nxt     = '0;
          produced_nxt     = '0;
          literal_left_nxt = '0;
          run_count_nxt    = '0;
          phase_nxt        = PH_CTRL;
          if (output_length_r == '0) begin
            phase_nxt = (block_size_nxt == '0) ? PH_HDR_LO : PH_SKIP;
          end
        end
        PH_CTRL: begin
          if (data_byte_i[CTRL_RUN_BIT]) begin
            run_count_nxt = data_byte_i[COUNT_W-1:0];
            phase_nxt     = PH_RUN;
          end else if (data_byte_i != '0) begin
            literal_left_nxt = (ctrl_count < remaining) ?
                               data_byte_i[COUNT_W-1:0] : remaining[COUNT_W-1:0];
            phase_nxt        = PH_LIT;
          end else begin
            phase_nxt = PH_PASS;
          end
        end
        PH_RUN: begin
          phase_nxt = PH_CTRL;
          emit_n    = (remaining < {{(LENGTH_W-COUNT_W){1'b0}}, run_count_r}) ?
                      remaining[COUNT_W-1:0] : run_count_r;
          do_emit   = (emit_n != '0);
        end
        PH_LIT: begin
          if (literal_left_r != '0) begin
            literal_left_nxt = literal_left_r - 7'd1;
          end
          if (literal_left_nxt == '0) begin
            phase_nxt = PH_CTRL;
          end
          emit_n  = 7'd1;
          do_emit = 1'b1;
        end
        PH_PASS: begin
          phase_nxt = PH_CTRL;
          emit_n    = 7'd1;
          do_emit   = 1'b1;
        end
        PH_SKIP: begin
          if (consumed_inc >= block_size_r) begin
            phase_nxt = PH_HDR_LO;
          end
        end
        // Header low byte; the unused phase code behaves the same way.
        default: begin
          header_low_nxt = data_byte_i;
          phase_nxt      = PH_HDR_HI;
        end
      endcase

      if (do_emit) begin
        produced_nxt = produced_sum;
        if (emit_last) begin
          phase_nxt = (consumed_inc >= block_size_r) ? PH_HDR_LO : PH_SKIP;
        end
      end
    end

    if (cfg_valid_i) begin
      output_length_nxt = cfg_output_length_i;
      // A shorter length can end the block that is being decoded.
      if (!accept_i && in_block && produced_r >= cfg_output_length_i) begin
        phase_nxt = (consumed_r >= block_size_r) ? PH_HDR_LO : PH_SKIP;
      end
    end
  end

  assign produced_sum = produced_r + {{(LENGTH_W-COUNT_W){1'b0}}, emit_n};
  assign emit_last    = (produced_sum >= output_length_r);

  assign res_valid_o      = do_emit;
  assign res_o.value      = data_byte_i;
  assign res_o.repeat_res = emit_n;
  assign res_o.block_last = emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HDR_LO;
      header_low_r    <= '0;
      block_size_r    <= '0;
      consumed_r      <= '0;
      produced_r      <= '0;
      literal_left_r  <= '0;
      run_count_r     <= '0;
      output_length_r <= OUTPUT_LENGTH_RESET;
    end else begin
      phase_r         <= phase_nxt;
      header_low_r    <= header_low_nxt;
      block_size_r    <= block_size_nxt;
      consumed_r      <= consumed_nxt;
      produced_r      <= produced_nxt;
      literal_left_r  <= literal_left_nxt;
      run_count_r     <= run_count_nxt;
      output_length_r <= output_length_nxt;
    end
  end

  // A run always carries at least one copy and never more than COUNT_MAX.
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_o |-> (res_o.repeat_res != '0 && res_o.repeat_res <= COUNT_MAX))
    else $error("run emitted with an out-of-range count");

  // The header resets the block counters.
  a_header_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_i && phase_r == PH_HDR_HI) |=> (produced_r == '0 && consumed_r == '0))
    else $error("block counters not cleared by header");

  // The last run of a block is followed by skip or header phase.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_o && res_o.block_last && !cfg_valid_i) |=>
      (phase_r == PH_HDR_LO || phase_r == PH_SKIP))
    else $error("block did not end after its last run");

endmodule

// File: rtl/rbd_queue.sv
// ----------------------------------------------------------------------------
// rbd_queue
// Small register queue between the parser and the result port; it holds
// decoded runs until the consumer pops them.
// ----------------------------------------------------------------------------
module rbd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  rbd_pkg::rbd_result_t  push_data_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output rbd_pkg::rbd_result_t  head_o
);
  import rbd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rbd_result_t       slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_r == CNT_FULL);
  assign empty_o = (count_r == '0);
  assign head_o  = slot_r[rd_ptr_r];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue occupancy beyond its depth");

  // The parser only pushes for a byte it was allowed to take.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("request pushed into a full queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy did not follow a push");

endmodule

// File: rtl/rle_block_decoder_core.sv
// ----------------------------------------------------------------------------
// rle_block_decoder_core
// Run-length block decoder: parses headers and control bytes and delivers
// each run as a (value, count) request through a result queue.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_push / in_full     in_data_byte
//  out_     output     out_empty / out_pop   out_value, out_repeat_res,
//                                            out_block_last
//  cfg_     input      cfg_valid / cfg_ready cfg_output_length
//
// One compressed byte is taken per cycle; a decoded run enters the result
// queue in the same cycle and can be popped from the next cycle on.
// The parser stalls only when the result queue holds QUEUE_DEPTH requests.
// cfg_ready is always high; the length register takes effect at once.
// Synchronous reset returns to the header phase with output length 768.
// ----------------------------------------------------------------------------
module rle_block_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  logic [7:0]   in_data_byte,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [7:0]   out_value,
  output logic [6:0]   out_repeat_res,
  output logic         out_block_last,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_output_length
);
  import rbd_pkg::*;

  logic        accept;
  logic        res_valid;
  rbd_result_t res;
  rbd_result_t head;

  assign accept    = in_push && !in_full;
  assign cfg_ready = 1'b1;

  rbd_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept_i            (accept),
    .data_byte_i         (in_data_byte),
    .cfg_valid_i         (cfg_valid),
    .cfg_output_length_i (cfg_output_length),
    .res_valid_o         (res_valid),
    .res_o               (res)
  );

  rbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (out_pop),
    .full_o      (in_full),
    .empty_o     (out_empty),
    .head_o      (head)
  );

  assign out_value      = head.value;
  assign out_repeat_res = head.repeat_res;
  assign out_block_last = head.block_last;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length block decoder. A byte-level model of
// the decoder predicts every (value, count) request from the accepted stream;
// the result queue is drained with random stalls and checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rbd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_CONTROL,
    PH_RUN_VALUE,
    PH_LITERAL,
    PH_COPY,
    PH_DISCARD
  } dec_phase_e;

  localparam logic [7:0] RUN_FLAG  = 8'h80;
  localparam logic [7:0] COPY_CTRL = 8'h00;
  localparam logic [7:0] LONG_RUN  = 8'hFF;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned DRAIN_LIMIT     = 5000;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_push           = 1'b0;
  logic [7:0]  in_data_byte      = 8'h00;
  logic        out_pop           = 1'b0;
  logic        cfg_valid         = 1'b0;
  logic [15:0] cfg_output_length = 16'h0000;
  logic        in_full;
  logic        out_empty;
  logic [7:0]  out_value;
  logic [6:0]  out_repeat_res;
  logic        out_block_last;
  logic        cfg_ready;

  rle_block_decoder_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_byte      (in_data_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_value         (out_value),
    .out_repeat_res    (out_repeat_res),
    .out_block_last    (out_block_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_output_length (cfg_output_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decoder state as the stream leaves it.
  logic [15:0] len_reg   = OUTPUT_LENGTH_RESET;
  dec_phase_e  dec_phase = PH_SIZE_LO;
  logic [7:0]  size_lo   = 8'h00;
  logic [15:0] blk_size  = 16'h0000;
  logic [15:0] used_cnt  = 16'h0000;
  logic [15:0] out_cnt   = 16'h0000;
  logic [6:0]  lit_left  = 7'd0;
  logic [6:0]  run_len   = 7'd0;

  rbd_result_t pending_runs[$];
  int unsigned err_count    = 0;
  int unsigned active_items = 0;
  int unsigned burst_left   = 0;
  int unsigned max_gap      = 5;
  int unsigned hold_cycles  = 0;
  int unsigned pop_pct      = 100;
  int unsigned pattern_left = 0;
  bit          drain_mode   = 1'b0;

  function automatic bit block_open();
    return dec_phase >= PH_CONTROL && dec_phase <= PH_COPY;
  endfunction

  // Once output is complete the block either skips its tail or, if the
  // compressed size is already used up, goes straight to the next header.
  function automatic void close_block();
    if (used_cnt >= blk_size) begin
      dec_phase = PH_SIZE_LO;
    end else begin
      dec_phase = PH_DISCARD;
    end
  endfunction

  function automatic logic [15:0] room();
    return (len_reg > out_cnt) ? len_reg - out_cnt : 16'd0;
  endfunction

  function automatic rbd_result_t make_run(input logic [7:0] v, input logic [6:0] n);
    rbd_result_t r;
    out_cnt      = out_cnt + 16'(n);
    r.value      = v;
    r.repeat_res = n;
    r.block_last = (out_cnt >= len_reg);
    if (r.block_last) close_block();
    return r;
  endfunction

  function automatic bit predict_byte(input logic [7:0] b, output rbd_result_t r);
    logic [15:0] n;
    r = '0;
    if ((block_open() || dec_phase == PH_DISCARD) && used_cnt < CONSUMED_MAX)
      used_cnt = used_cnt + 16'd1;
    case (dec_phase)
      PH_SIZE_HI: begin
        blk_size  = {b, size_lo};
        used_cnt  = 16'd0;
        out_cnt   = 16'd0;
        lit_left  = 7'd0;
        run_len   = 7'd0;
        dec_phase = PH_CONTROL;
        if (out_cnt >= len_reg) close_block();
        return 1'b0;
      end
      PH_CONTROL: begin
        if (b[CTRL_RUN_BIT]) begin
          run_len   = b[6:0];
          dec_phase = PH_RUN_VALUE;
        end else if (b != COPY_CTRL) begin
          n         = room();
          lit_left  = (16'(b) < n) ? b[6:0] : n[6:0];
          dec_phase = PH_LITERAL;
        end else begin
          dec_phase = PH_COPY;
        end
        return 1'b0;
      end
      PH_RUN_VALUE: begin
        n = room();
        if (16'(run_len) < n) n = 16'(run_len);
        dec_phase = PH_CONTROL;
        if (n == 16'd0) return 1'b0;
        r = make_run(b, n[6:0]);
        return 1'b1;
      end
      PH_LITERAL: begin
        if (lit_left > 7'd0) lit_left = lit_left - 7'd1;
        if (lit_left == 7'd0) dec_phase = PH_CONTROL;
        r = make_run(b, 7'd1);
        return 1'b1;
      end
      PH_COPY: begin
        dec_phase = PH_CONTROL;
        r = make_run(b, 7'd1);
        return 1'b1;
      end
      PH_DISCARD: begin
        if (used_cnt >= blk_size) dec_phase = PH_SIZE_LO;
        return 1'b0;
      end
      default: begin
        size_lo   = b;
        dec_phase = PH_SIZE_HI;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void apply_length(input logic [15:0] v);
    len_reg = v;
    if (block_open() && out_cnt >= len_reg) close_block();
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_runs
    rbd_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected request value %0d count %0d last %0d",
                                  out_value, out_repeat_res, out_block_last));
      end else begin
        want = pending_runs.pop_front();
        if (out_value !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d", out_value, want.value));
        if (out_repeat_res !== want.repeat_res)
          report_mismatch($sformatf("count %0d, expected %0d",
                                    out_repeat_res, want.repeat_res));
        if (out_block_last !== want.block_last)
          report_mismatch($sformatf("block_last %0d, expected %0d",
                                    out_block_last, want.block_last));
      end
    end
  end

  // Receiver: a long hold-off when asked, otherwise a pop rate that is redrawn
  // at random from a fixed set, full rate included.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_pop <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 4))
          0, 1: pop_pct = 100;
          2: pop_pct = 70;
          3: pop_pct = 40;
          default: pop_pct = 15;
        endcase
      end
      pattern_left = pattern_left - 1;
      out_pop <= drain_mode || ($urandom_range(1, 100) <= pop_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    rbd_result_t r;
    int unsigned gap;
    bit          was_skip;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_push      <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_full);
    was_skip = (dec_phase == PH_DISCARD);
    if (predict_byte(b, r)) pending_runs.push_back(r);
    if (!was_skip) active_items++;
  endtask

  task automatic send_seq(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_runs.size() != 0) begin
      report_mismatch($sformatf("%0d requests never arrived", pending_runs.size()));
      pending_runs.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [15:0] v);
    cfg_valid         <= 1'b1;
    cfg_output_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_length(v);
  endtask

  // Zero-length run, single run, copy, literal, a clamped long run, a skipped
  // tail, a block whose size is already used up, and a literal cut short.
  task automatic test_directed_runs();
    write_length(16'd10);
    send_seq('{8'h0C, 8'h00, RUN_FLAG, 8'h11, 8'h81, 8'h00, COPY_CTRL, 8'hFF,
               8'h02, 8'hAA, 8'h55, LONG_RUN, 8'h3C, 8'h5A});
    send_seq('{8'h01, 8'h00, 8'h8A, 8'hEE});
    wait_idle();
    write_length(16'd1);
    send_seq('{8'h00, 8'h00, 8'h05, 8'h99});
  endtask

  // Zero output length, then a length write that ends a block in progress.
  task automatic test_length_edges();
    wait_idle();
    write_length(16'd0);
    send_seq('{8'h03, 8'h00, 8'hAB, 8'hCD, 8'hEF, 8'h00, 8'h00});
    wait_idle();
    write_length(16'd300);
    send_seq('{8'h04, 8'h00, LONG_RUN, 8'h01, LONG_RUN, 8'h02});
    wait_idle();
    write_length(16'd200);
  endtask

  // A length above 255 built from long runs, ended by a short run that lands
  // exactly on it, followed by a skipped tail.
  task automatic test_full_length();
    wait_idle();
    write_length(16'd3940);
    send_seq('{8'h46, 8'h00});
    repeat (31) begin
      send_byte(LONG_RUN);
      send_byte(rand_byte());
    end
    send_seq('{8'h83, rand_byte()});
    repeat (6) send_byte(rand_byte());
  endtask

  // The decoder queue holds only a few requests, so a long hold-off on the
  // result side backs up the input while literals keep arriving.
  task automatic test_backpressure();
    wait_idle();
    write_length(16'd127);
    send_seq('{8'h80, 8'h00});
    hold_cycles = HOLD_OFF_CYCLES;
    send_byte(8'h7F);
    repeat (127) send_byte(rand_byte());
  endtask

  task automatic test_random_blocks(input int unsigned target);
    logic [7:0]  body[$];
    logic [7:0]  b;
    int unsigned first, goal, planned, n, m, blk;
    first = active_items;
    while (active_items - first < target) begin
      // Bring the stream back to a header boundary quickly.
      while (dec_phase != PH_SIZE_LO) begin
        case (dec_phase)
          PH_SIZE_HI: b = 8'h00;
          PH_CONTROL: b = LONG_RUN;
          default:    b = rand_byte();
        endcase
        send_byte(b);
      end
      if ($urandom_range(0, 4) == 0) begin
        wait_idle();
        case ($urandom_range(0, 9))
          0:             write_length(16'd1);
          1, 2, 3, 4, 5: write_length(16'($urandom_range(1, 40)));
          6, 7, 8:       write_length(16'($urandom_range(41, 400)));
          default:       write_length(16'($urandom_range(401, 1500)));
        endcase
      end
      goal    = len_reg;
      planned = 0;
      body.delete();
      while (planned < goal && body.size() < 600) begin
        case ($urandom_range(0, 9))
          0: begin
            body.push_back(RUN_FLAG);
            body.push_back(rand_byte());
          end
          1: begin
            body.push_back(COPY_CTRL);
            body.push_back(rand_byte());
            planned++;
          end
          2, 3, 4: begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
            m = (n < goal - planned) ? n : goal - planned;
            body.push_back(8'(n));
            repeat (m) body.push_back(rand_byte());
            planned += m;
          end
          default: begin
            n = $urandom_range(1, 127);
            body.push_back(RUN_FLAG | 8'(n));
            body.push_back(rand_byte());
            planned += (n < goal - planned) ? n : goal - planned;
          end
        endcase
      end
      if ($urandom_range(0, 7) == 0 && body.size() > 0) begin
        repeat ($urandom_range(1, 3)) body[$urandom_range(0, body.size() - 1)] = rand_byte();
      end
      if ($urandom_range(0, 3) == 0) begin
        blk = $urandom_range(0, body.size());
      end else begin
        blk = body.size() + $urandom_range(0, 4);
      end
      send_byte(blk[7:0]);
      send_byte(blk[15:8]);
      foreach (body[i]) begin
        if (!block_open()) break;
        send_byte(body[i]);
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) if (block_open()) send_byte(rand_byte());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_runs();
    test_length_edges();
    test_full_length();
    test_backpressure();
    test_random_blocks(500);
    drain_mode = 1'b1;
    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/rbd_pkg.sv
rtl/rbd_front.sv
rtl/rbd_queue.sv
rtl/rle_block_decoder_core.sv
bench/tb_top.sv
